@@ hdl/krlr_pkg.sv @@
// Shared types, constants and functions of the keyboard report layout remapper.
// Holds the held-key entry format, report format, sequencer states and remap table.
// No dependencies.
package krlr_pkg;

    localparam logic [7:0] SHIFT_BITS = 8'h22;
    localparam logic [7:0] ALT_BITS   = 8'h44;
    localparam logic [7:0] LSHIFT     = 8'h02;
    localparam logic [7:0] RSHIFT     = 8'h20;
    localparam logic [7:0] LALT       = 8'h04;
    localparam logic [7:0] RALT       = 8'h40;
    localparam logic [7:0] ALL_MODS   = 8'hff;
    localparam int unsigned TABLE_MAX = 32;

    typedef enum logic [1:0] {
        MT_SHIFT   = 2'd0,
        MT_NOSHIFT = 2'd1,
        MT_ALT     = 2'd2,
        MT_NOALT   = 2'd3
    } t_mt;

    typedef struct packed {
        logic [7:0] key_in;
        t_mt        type_in;
        logic [7:0] key_out;
        t_mt        type_out;
    } t_map;

    typedef struct packed {
        logic [7:0] code_in;
        logic [7:0] code_out;
        logic [7:0] mods;
        logic [7:0] lock;
        logic       send;
    } t_held;

    typedef struct packed {
        logic [5:0][7:0] keys;
        logic [7:0]      mods;
    } t_rep;

    typedef struct packed {
        t_rep rep;
        logic last;
    } t_emit;

    typedef struct packed {
        logic [7:0] code;
        logic [7:0] mods;
        logic [7:0] lock;
    } t_remap;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL_RD,
        S_REL_EV,
        S_MB_RD,
        S_MB_EV,
        S_ADD,
        S_RS_RD,
        S_RS_EV,
        S_FL_RD,
        S_FL_EV,
        S_FL_CMP,
        S_PUSH,
        S_RET,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RET_MB,
        RET_RS,
        RET_FIN
    } t_ret;

    localparam t_map REMAP_TABLE [TABLE_MAX] = '{
        '{8'h35, MT_ALT,     8'h35, MT_ALT},
        '{8'h1f, MT_SHIFT,   8'h2f, MT_NOSHIFT},
        '{8'h23, MT_SHIFT,   8'h2e, MT_NOSHIFT},
        '{8'h24, MT_SHIFT,   8'h23, MT_SHIFT},
        '{8'h25, MT_SHIFT,   8'h34, MT_SHIFT},
        '{8'h26, MT_SHIFT,   8'h25, MT_SHIFT},
        '{8'h27, MT_SHIFT,   8'h26, MT_SHIFT},
        '{8'h2d, MT_SHIFT,   8'h87, MT_SHIFT},
        '{8'h2e, MT_SHIFT,   8'h33, MT_SHIFT},
        '{8'h31, MT_SHIFT,   8'h89, MT_SHIFT},
        '{8'h35, MT_SHIFT,   8'h2e, MT_SHIFT},
        '{8'h2f, MT_SHIFT,   8'h30, MT_SHIFT},
        '{8'h30, MT_SHIFT,   8'h32, MT_SHIFT},
        '{8'h33, MT_SHIFT,   8'h34, MT_NOSHIFT},
        '{8'h34, MT_SHIFT,   8'h1f, MT_SHIFT},
        '{8'h31, MT_NOSHIFT, 8'h89, MT_NOSHIFT},
        '{8'h2f, MT_NOSHIFT, 8'h30, MT_NOSHIFT},
        '{8'h30, MT_NOSHIFT, 8'h32, MT_NOSHIFT},
        '{8'h2e, MT_NOSHIFT, 8'h2d, MT_SHIFT},
        '{8'h35, MT_NOSHIFT, 8'h2f, MT_SHIFT},
        '{8'h34, MT_NOSHIFT, 8'h24, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT},
        '{8'h00, MT_SHIFT,   8'h00, MT_SHIFT}
    };

    function automatic logic conflicts(input logic [7:0] m1, input logic [7:0] l1,
                                       input logic [7:0] m2, input logic [7:0] l2);
        conflicts = (((m1 ^ m2) & l1 & l2) != 8'h00);
    endfunction

    function automatic logic type_matches(input t_mt t, input logic [7:0] mods);
        logic r;
        case (t)
            MT_SHIFT:   r = ((mods & SHIFT_BITS) != 8'h00);
            MT_NOSHIFT: r = ((mods & SHIFT_BITS) == 8'h00);
            MT_ALT:     r = ((mods & ALT_BITS) != 8'h00);
            MT_NOALT:   r = ((mods & ALT_BITS) == 8'h00);
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_remap rewrite(input t_mt t, input logic [7:0] in);
        t_remap r;
        r.code = 8'h00;
        case (t)
            MT_SHIFT: begin
                r.lock = ((in & RSHIFT) != 8'h00) ? RSHIFT : LSHIFT;
                r.mods = ((in & SHIFT_BITS) != 8'h00) ? in : (in | LSHIFT);
            end
            MT_ALT: begin
                r.lock = ((in & RALT) != 8'h00) ? RALT : LALT;
                r.mods = ((in & ALT_BITS) != 8'h00) ? in : (in | LALT);
            end
            MT_NOSHIFT: begin
                r.lock = SHIFT_BITS;
                r.mods = in & ~SHIFT_BITS;
            end
            MT_NOALT: begin
                r.lock = ALT_BITS;
                r.mods = in & ~ALT_BITS;
            end
            default: begin
                r.lock = 8'h00;
                r.mods = in;
            end
        endcase
        return r;
    endfunction

    // First matching table entry wins; no match passes the key through.
    function automatic t_remap remap(input logic [7:0] key, input logic [7:0] cur,
                                     input int unsigned n);
        t_remap r;
        t_remap w;
        logic   hit;
        r.code = key;
        r.mods = 8'h00;
        r.lock = 8'h00;
        hit = 1'b0;
        for (int unsigned e = 0; e < TABLE_MAX; e++) begin
            if (!hit && e < n && REMAP_TABLE[e].key_in == key &&
                type_matches(REMAP_TABLE[e].type_in, cur)) begin
                hit = 1'b1;
                w = rewrite(REMAP_TABLE[e].type_out, cur);
                r.code = REMAP_TABLE[e].key_out;
                r.mods = w.mods;
                r.lock = w.lock;
            end
        end
        return r;
    endfunction

endpackage

@@ hdl/krlr_held_ram.sv @@
// Held-key list storage: one write port, one read port, registered read data.
// Depends on krlr_pkg for the entry format.
module krlr_held_ram import krlr_pkg::*; #(
    parameter int DEPTH = 12,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_held         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_held         o_rdata
);

    t_held r_mem [DEPTH];
    t_held r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/krlr_seq.sv @@
// Report sequencer: walks the held-key list in memory for release, modifier
// change, key add, conflict resolution and report flushes. Depends on krlr_pkg.
module krlr_seq import krlr_pkg::*; #(
    parameter int KEY_SLOTS     = 6,
    parameter int HELD_DEPTH    = 12,
    parameter int TABLE_ENTRIES = 21,
    parameter int AW            = 4,
    parameter int CW            = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_mods,
    input  logic [5:0][7:0]     i_keys,
    output logic                o_emit_valid,
    input  logic                i_emit_ready,
    output t_emit               o_emit,
    output logic                o_we,
    output logic [AW-1:0]       o_waddr,
    output t_held               o_wdata,
    output logic [AW-1:0]       o_raddr,
    input  t_held               i_rdata
);

    t_state          r_state, n_state;
    t_ret            r_ret;
    logic [7:0]      r_mods_in, r_cur;
    logic [5:0][7:0] r_keys;
    logic [5:0]      r_used;
    logic [CW-1:0]   r_count, r_i, r_dst, r_k, r_end, r_fslot;
    logic [2:0]      r_slot;
    logic [7:0]      r_m, r_l, r_cm, r_cl, r_fm, r_fl, r_hm, r_hl;
    t_rep            r_rep, r_last_sent, r_pend, rep_init;
    logic            r_pend_valid;

    logic [5:0]      found_oh;
    logic            found;
    logic            add_ok;
    logic            go_mb;
    logic            rep_diff;
    t_remap          nk;
    t_held           new_entry, muted;

    always_comb begin
        found_oh = 6'b0;
        found    = 1'b0;
        for (int j = 0; j < 6; j++) begin
            if (!found && r_keys[j] == i_rdata.code_in) begin
                found       = 1'b1;
                found_oh[j] = 1'b1;
            end
        end
    end

    assign nk     = remap(r_keys[r_slot], r_cur, TABLE_ENTRIES);
    assign add_ok = !r_used[r_slot] && (r_keys[r_slot] != 8'h00) &&
                    (r_count < CW'(HELD_DEPTH));
    assign go_mb  = (r_cur != r_mods_in) && (r_dst != '0);
    assign rep_diff = (r_rep != r_last_sent);

    always_comb begin
        new_entry.code_in  = r_keys[r_slot];
        new_entry.code_out = nk.code;
        new_entry.mods     = nk.mods;
        new_entry.lock     = nk.lock;
        new_entry.send     = 1'b1;
        muted              = i_rdata;
        muted.send         = 1'b0;
        rep_init.keys      = '0;
        rep_init.mods      = r_cur;
    end

    always_comb begin
        n_state      = r_state;
        o_we         = 1'b0;
        o_waddr      = r_dst[AW-1:0];
        o_wdata      = i_rdata;
        o_raddr      = r_i[AW-1:0];
        o_emit_valid = 1'b0;
        o_emit.rep   = r_pend;
        o_emit.last  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_REL_RD;
            end
            S_REL_RD: begin
                if (r_i == r_count) n_state = go_mb ? S_MB_RD : S_ADD;
                else n_state = S_REL_EV;
            end
            S_REL_EV: begin
                o_we    = found;
                n_state = S_REL_RD;
            end
            S_MB_RD: begin
                n_state = (r_i == r_count) ? S_ADD : S_MB_EV;
            end
            S_MB_EV: begin
                if (i_rdata.send && conflicts(i_rdata.mods, i_rdata.lock, r_mods_in, ALL_MODS))
                    n_state = S_FL_RD;
                else
                    n_state = S_MB_RD;
            end
            S_ADD: begin
                o_we    = add_ok;
                o_waddr = r_count[AW-1:0];
                o_wdata = new_entry;
                if (r_slot == 3'd5) n_state = S_RS_RD;
            end
            S_RS_RD: begin
                n_state = (r_i == r_count) ? S_FL_RD : S_RS_EV;
            end
            S_RS_EV: begin
                if (i_rdata.send && conflicts(r_m, r_l, i_rdata.mods, i_rdata.lock))
                    n_state = S_FL_RD;
                else
                    n_state = S_RS_RD;
            end
            S_FL_RD: begin
                o_raddr = r_k[AW-1:0];
                n_state = (r_k == r_end) ? S_FL_CMP : S_FL_EV;
            end
            S_FL_EV: begin
                o_waddr = r_k[AW-1:0];
                o_wdata = muted;
                o_we    = i_rdata.send && conflicts(r_cm, r_cl, i_rdata.mods, i_rdata.lock);
                n_state = S_FL_RD;
            end
            S_FL_CMP: begin
                n_state = (rep_diff && r_pend_valid) ? S_PUSH : S_RET;
            end
            S_PUSH: begin
                o_emit_valid = 1'b1;
                if (i_emit_ready) n_state = S_RET;
            end
            S_RET: begin
                case (r_ret)
                    RET_MB:  n_state = S_MB_RD;
                    RET_RS:  n_state = S_RS_RD;
                    RET_FIN: n_state = S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_DONE: begin
                o_emit_valid = r_pend_valid;
                o_emit.last  = 1'b1;
                if (!r_pend_valid || i_emit_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_cur        <= 8'h00;
            r_last_sent  <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_mods_in <= i_mods;
                        for (int j = 0; j < 6; j++) begin
                            r_keys[j] <= (j < KEY_SLOTS) ? i_keys[j] : 8'h00;
                        end
                        r_i    <= '0;
                        r_dst  <= '0;
                        r_used <= '0;
                    end
                end
                S_REL_RD: begin
                    if (r_i == r_count) begin
                        r_count <= r_dst;
                        r_i     <= '0;
                        r_slot  <= '0;
                        if (!go_mb) r_cur <= r_mods_in;
                    end
                end
                S_REL_EV: begin
                    r_i <= r_i + 1'b1;
                    if (found) begin
                        r_dst  <= r_dst + 1'b1;
                        r_used <= r_used | found_oh;
                    end
                end
                S_MB_RD: begin
                    if (r_i == r_count) begin
                        r_cur  <= r_mods_in;
                        r_slot <= '0;
                    end
                end
                S_MB_EV: begin
                    r_i <= r_i + 1'b1;
                    r_end   <= r_i + 1'b1;
                    r_cm    <= r_mods_in;
                    r_cl    <= ALL_MODS;
                    r_ret   <= RET_MB;
                    r_k     <= '0;
                    r_fslot <= '0;
                    r_rep   <= rep_init;
                    r_fm    <= r_cur;
                    r_fl    <= 8'h00;
                end
                S_ADD: begin
                    if (add_ok) r_count <= r_count + 1'b1;
                    r_slot <= r_slot + 1'b1;
                    r_m    <= r_cur;
                    r_l    <= 8'h00;
                    r_i    <= '0;
                end
                S_RS_RD: begin
                    r_end   <= r_count;
                    r_cm    <= 8'h00;
                    r_cl    <= 8'h00;
                    r_ret   <= RET_FIN;
                    r_k     <= '0;
                    r_fslot <= '0;
                    r_rep   <= rep_init;
                    r_fm    <= r_cur;
                    r_fl    <= 8'h00;
                end
                S_RS_EV: begin
                    r_i     <= r_i + 1'b1;
                    r_end   <= r_i;
                    r_cm    <= i_rdata.mods;
                    r_cl    <= i_rdata.lock;
                    r_hm    <= i_rdata.mods;
                    r_hl    <= i_rdata.lock;
                    r_ret   <= RET_RS;
                    r_k     <= '0;
                    r_fslot <= '0;
                    r_rep   <= rep_init;
                    r_fm    <= r_cur;
                    r_fl    <= 8'h00;
                    if (i_rdata.send && !conflicts(r_m, r_l, i_rdata.mods, i_rdata.lock)) begin
                        r_m <= (r_m & ~i_rdata.lock) | i_rdata.mods;
                        r_l <= r_l | i_rdata.lock;
                    end
                end
                S_FL_EV: begin
                    r_k <= r_k + 1'b1;
                    if (i_rdata.send) begin
                        if (r_fslot < CW'(KEY_SLOTS)) begin
                            r_rep.keys[r_fslot[2:0]] <= i_rdata.code_out;
                        end
                        r_fslot    <= r_fslot + 1'b1;
                        r_rep.mods <= (r_rep.mods & ~i_rdata.lock) | i_rdata.mods;
                        if (!conflicts(r_cm, r_cl, i_rdata.mods, i_rdata.lock)) begin
                            r_fm <= (r_fm & ~i_rdata.lock) | i_rdata.mods;
                            r_fl <= r_fl | i_rdata.lock;
                        end
                    end
                end
                S_FL_CMP: begin
                    if (rep_diff) begin
                        r_last_sent <= r_rep;
                        if (!r_pend_valid) begin
                            r_pend       <= r_rep;
                            r_pend_valid <= 1'b1;
                        end
                    end
                end
                S_PUSH: begin
                    if (i_emit_ready) r_pend <= r_rep;
                end
                S_RET: begin
                    if (r_ret == RET_RS) begin
                        r_m <= (r_fm & ~r_hl) | r_hm;
                        r_l <= r_fl | r_hl;
                    end
                end
                S_DONE: begin
                    if (i_emit_ready) r_pend_valid <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HELD_DEPTH))
        else $error("held count beyond depth");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_valid)
        else $error("pending report left over at idle");

    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FL_EV |-> r_k < r_end)
        else $error("flush walked past its end");

    a_push_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PUSH |-> r_pend_valid)
        else $error("push without pending report");

endmodule

@@ hdl/keyboard_report_layout_remapper.sv @@
// Top level of the keyboard report layout remapper: held-key RAM, sequencer and
// output register. Depends on krlr_pkg, krlr_held_ram and krlr_seq.
//
// Takes boot-protocol keyboard reports (modifier byte plus six key codes) and
// sends reports with US layout keys remapped to their JP layout codes and the
// shift/alt state each remapped key needs. Held keys live in a small RAM with
// registered read data; a sequencer walks it entry by entry (read, then
// evaluate and write back). Per item it runs a release-and-compact pass, an
// optional modifier-change pass, six add steps and a conflict pass; each
// conflict triggers a flush sweep over the leading part of the list that
// builds one report and mutes conflicting keys, and a last sweep over the
// whole list closes the item. o_stall stays high until every report of an
// item has been handed to the output register. Reports equal to the last one
// sent are dropped; o_last marks the final report of an item, and an item may
// produce no report at all.
module keyboard_report_layout_remapper import krlr_pkg::*; #(
    parameter int KEY_SLOTS     = 6,
    parameter int HELD_DEPTH    = 12,
    parameter int TABLE_ENTRIES = 21
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_modifiers,
    input  logic [7:0] i_in_key_0,
    input  logic [7:0] i_in_key_1,
    input  logic [7:0] i_in_key_2,
    input  logic [7:0] i_in_key_3,
    input  logic [7:0] i_in_key_4,
    input  logic [7:0] i_in_key_5,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_modifiers,
    output logic [7:0] o_out_key_0,
    output logic [7:0] o_out_key_1,
    output logic [7:0] o_out_key_2,
    output logic [7:0] o_out_key_3,
    output logic [7:0] o_out_key_4,
    output logic [7:0] o_out_key_5,
    output logic       o_last
);

    localparam int AW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int CW = $clog2(HELD_DEPTH + 1);

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    t_held           wdata, rdata;
    logic            emit_valid, emit_ready;
    t_emit           emit;
    logic [5:0][7:0] in_keys;
    logic            r_out_valid;
    t_emit           r_out;

    assign in_keys = {i_in_key_5, i_in_key_4, i_in_key_3,
                      i_in_key_2, i_in_key_1, i_in_key_0};

    krlr_held_ram #(
        .DEPTH (HELD_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    krlr_seq #(
        .KEY_SLOTS     (KEY_SLOTS),
        .HELD_DEPTH    (HELD_DEPTH),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW),
        .CW            (CW)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mods       (i_in_modifiers),
        .i_keys       (in_keys),
        .o_emit_valid (emit_valid),
        .i_emit_ready (emit_ready),
        .o_emit       (emit),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    // Load a new report whenever the output register is empty or being drained.
    assign emit_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ready) begin
            r_out_valid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ready && emit_valid) begin
            r_out <= emit;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_modifiers = r_out.rep.mods;
    assign o_out_key_0     = r_out.rep.keys[0];
    assign o_out_key_1     = r_out.rep.keys[1];
    assign o_out_key_2     = r_out.rep.keys[2];
    assign o_out_key_3     = r_out.rep.keys[3];
    assign o_out_key_4     = r_out.rep.keys[4];
    assign o_out_key_5     = r_out.rep.keys[5];
    assign o_last          = r_out.last;

endmodule
